// File: rtl/gmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gmr_pkg;

   // default geometry
   localparam int MAP_SIDE_DEF  = 16;
   localparam int MAX_STEPS_DEF = 512;
   localparam int CELL_SIZE_DEF = 64;

   // field widths
   localparam int INDEX_W = 8;
   localparam int TYPE_W  = 2;
   localparam int POS_W   = 16;
   localparam int ANGLE_W = 12;
   localparam int DIR_W   = 16;
   localparam int SINE_W  = 15;

   localparam int MAP_DEPTH = 1 << INDEX_W;

   // angle landmarks, full turn = 4096
   localparam int QUARTER_TURN = 1024;
   localparam int HALF_TURN    = 2048;
   localparam int THREE_TURN   = 3072;
   localparam int FULL_TURN    = 4096;
   localparam int EIGHTH_TURN  = QUARTER_TURN / 2;

   localparam int ROM_DEPTH  = QUARTER_TURN + 1;
   localparam int ROM_ADDR_W = $clog2(ROM_DEPTH);

   localparam int QUEUE_DEPTH = 2;

   // commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // block types
   localparam logic [TYPE_W-1:0] TYPE_EMPTY = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_WALL  = 2'd1;

   // half of one output lsb in the 8 extra fraction bits of dir * step
   localparam int STEP_ROUND = 128;
   localparam int STEP_SHIFT = 8;

   localparam int FRAC_SCALE = 64;

   typedef struct packed {
      logic                     command;
      logic [INDEX_W-1:0]       cell_index;
      logic [TYPE_W-1:0]        cell_type;
      logic [POS_W-1:0]         start_x;
      logic [POS_W-1:0]         start_y;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
   } entry_type;

   typedef logic [SINE_W-1:0] quarter_rom_type [0:ROM_DEPTH-1];

   localparam longint Q30_ONE = longint'(1) << 30;
   localparam longint PI_Q30  = 64'sd3373259426;

   function automatic longint angle_q30(input longint k);
      return (k * PI_Q30 + 64'sd1024) / 64'sd2048;
   endfunction

   // eight series terms, divisors (2n)(2n+1)
   function automatic longint taylor_sin(input longint x);
      longint x2;
      longint term;
      longint sum;
      x2   = (x * x) / Q30_ONE;
      term = x;
      sum  = x;
      term = -((term * x2) / Q30_ONE) / 64'sd6;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd20;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd42;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd72;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd110;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd156;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd210;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd272;
      sum  = sum + term;
      return sum;
   endfunction

   // eight series terms, divisors (2n-1)(2n)
   function automatic longint taylor_cos(input longint x);
      longint x2;
      longint term;
      longint sum;
      x2   = (x * x) / Q30_ONE;
      term = Q30_ONE;
      sum  = Q30_ONE;
      term = -((term * x2) / Q30_ONE) / 64'sd2;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd12;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd30;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd56;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd90;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd132;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd182;
      sum  = sum + term;
      term = -((term * x2) / Q30_ONE) / 64'sd240;
      sum  = sum + term;
      return sum;
   endfunction

   function automatic longint quarter_sine(input int k);
      longint v;
      if (k <= EIGHTH_TURN) begin
         v = taylor_sin(angle_q30(longint'(k)));
      end else begin
         v = taylor_cos(angle_q30(longint'(QUARTER_TURN - k)));
      end
      if (v < 0) begin
         v = 0;
      end
      return (v + 64'sd32768) >>> 16;
   endfunction

   // q1.14 sine over the first quadrant, built at elaboration
   function automatic quarter_rom_type build_quarter_rom();
      quarter_rom_type rom;
      int              k;
      for (k = 0; k < ROM_DEPTH; k++) begin
         rom[k] = SINE_W'(quarter_sine(k));
      end
      return rom;
   endfunction

   localparam quarter_rom_type QUARTER_ROM = build_quarter_rom();

endpackage

`default_nettype wire

// File: rtl/gmr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gmr_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [gmr_pkg::INDEX_W-1:0] cell_index;
   logic [gmr_pkg::TYPE_W-1:0]  cell_type;
   logic [gmr_pkg::POS_W-1:0]   start_x;
   logic [gmr_pkg::POS_W-1:0]   start_y;
   logic [gmr_pkg::ANGLE_W-1:0] ray_angle;

   modport source (
      output valid, command, cell_index, cell_type, start_x, start_y, ray_angle,
      input  ready
   );
   modport sink (
      input  valid, command, cell_index, cell_type, start_x, start_y, ray_angle,
      output ready
   );
endinterface

interface gmr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic [gmr_pkg::POS_W-1:0]  hit_x;
   logic [gmr_pkg::POS_W-1:0]  hit_y;
   logic [gmr_pkg::TYPE_W-1:0] hit_type;

   modport source (
      output valid, hit, hit_x, hit_y, hit_type,
      input  ready
   );
   modport sink (
      input  valid, hit, hit_x, hit_y, hit_type,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/gmr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gmr_front (
   input  wire logic          clock,
   input  wire logic          reset,
   gmr_req_if.sink            req_if,
   input  wire logic          q_full,
   output logic               q_push,
   output gmr_pkg::entry_type q_push_data
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_SIN  = 2'd1;
   localparam logic [1:0] F_COS  = 2'd2;

   typedef struct packed {
      logic                           neg;
      logic [gmr_pkg::ROM_ADDR_W-1:0] addr;
   } fold_type;

   // fold a full-turn angle onto the first quadrant table
   function automatic fold_type fold_angle(input logic [gmr_pkg::ANGLE_W-1:0] a);
      fold_type                   f;
      logic [gmr_pkg::ANGLE_W:0]  w;
      w = {1'b0, a};
      if (w <= (gmr_pkg::ANGLE_W + 1)'(gmr_pkg::QUARTER_TURN)) begin
         f.neg  = 1'b0;
         f.addr = gmr_pkg::ROM_ADDR_W'(w);
      end else if (w <= (gmr_pkg::ANGLE_W + 1)'(gmr_pkg::HALF_TURN)) begin
         f.neg  = 1'b0;
         f.addr = gmr_pkg::ROM_ADDR_W'((gmr_pkg::ANGLE_W + 1)'(gmr_pkg::HALF_TURN) - w);
      end else if (w <= (gmr_pkg::ANGLE_W + 1)'(gmr_pkg::THREE_TURN)) begin
         f.neg  = 1'b1;
         f.addr = gmr_pkg::ROM_ADDR_W'(w - (gmr_pkg::ANGLE_W + 1)'(gmr_pkg::HALF_TURN));
      end else begin
         f.neg  = 1'b1;
         f.addr = gmr_pkg::ROM_ADDR_W'((gmr_pkg::ANGLE_W + 1)'(gmr_pkg::FULL_TURN) - w);
      end
      return f;
   endfunction

   function automatic logic signed [gmr_pkg::DIR_W-1:0] signed_dir(
      input logic [gmr_pkg::SINE_W-1:0] mag,
      input logic                       neg
   );
      logic [gmr_pkg::DIR_W-1:0] m;
      m = gmr_pkg::DIR_W'(mag);
      return neg ? -m : m;
   endfunction

   logic [1:0]                         state_ff;
   logic [1:0]                         state_in;
   logic [gmr_pkg::ANGLE_W-1:0]        ang_ff;
   logic                               neg_ff;
   logic [gmr_pkg::SINE_W-1:0]         rom_q_ff;
   logic [gmr_pkg::POS_W-1:0]          sx_ff;
   logic [gmr_pkg::POS_W-1:0]          sy_ff;
   logic signed [gmr_pkg::DIR_W-1:0]   dir_y_ff;
   logic signed [gmr_pkg::DIR_W-1:0]   dir_now;
   fold_type                           fold_req;
   fold_type                           fold_cos;
   logic [gmr_pkg::ROM_ADDR_W-1:0]     rom_addr;
   logic                               accept;

   assign req_if.ready = (state_ff == F_IDLE) && !q_full;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      fold_req = fold_angle(req_if.ray_angle);
      fold_cos = fold_angle(ang_ff + gmr_pkg::ANGLE_W'(gmr_pkg::QUARTER_TURN));
      rom_addr = (state_ff == F_IDLE) ? fold_req.addr : fold_cos.addr;
      dir_now  = signed_dir(rom_q_ff, neg_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept && (req_if.command == gmr_pkg::CMD_CAST)) begin
               state_in = F_SIN;
            end
         end
         F_SIN:   state_in = F_COS;
         F_COS:   state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= gmr_pkg::QUARTER_ROM[rom_addr];
      if (accept) begin
         ang_ff <= req_if.ray_angle;
         sx_ff  <= req_if.start_x;
         sy_ff  <= req_if.start_y;
         neg_ff <= fold_req.neg;
      end
      // sine arrives first, then the cosine read is in flight
      if (state_ff == F_SIN) begin
         dir_y_ff <= dir_now;
         neg_ff   <= fold_cos.neg;
      end
   end

   always_comb begin
      q_push = (accept && (req_if.command == gmr_pkg::CMD_WRITE)) || (state_ff == F_COS);
      q_push_data = '0;
      if (state_ff == F_COS) begin
         q_push_data.command = gmr_pkg::CMD_CAST;
         q_push_data.start_x = sx_ff;
         q_push_data.start_y = sy_ff;
         q_push_data.dir_x   = dir_now;
         q_push_data.dir_y   = dir_y_ff;
      end else begin
         q_push_data.command    = gmr_pkg::CMD_WRITE;
         q_push_data.cell_index = req_if.cell_index;
         q_push_data.cell_type  = req_if.cell_type;
      end
   end

endmodule

`default_nettype wire

// File: rtl/gmr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gmr_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire gmr_pkg::entry_type push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               valid,
   output gmr_pkg::entry_type pop_data
);

   localparam int PTR_W = $clog2(gmr_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(gmr_pkg::QUEUE_DEPTH + 1);

   gmr_pkg::entry_type  entries_ff [gmr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_W'(gmr_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // depth is a power of two, pointers wrap on their own
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/gmr_march.sv
`timescale 1ns / 1ps
`default_nettype none

module gmr_march #(
   parameter int MAP_SIDE  = gmr_pkg::MAP_SIDE_DEF,
   parameter int MAX_STEPS = gmr_pkg::MAX_STEPS_DEF,
   parameter int CELL_SIZE = gmr_pkg::CELL_SIZE_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire gmr_pkg::entry_type q_data,
   output logic               q_pop,
   gmr_rsp_if.source          rsp_if
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_RUN  = 2'd1;
   localparam logic [1:0] B_DONE = 2'd2;

   localparam int STEP_W   = $clog2(MAX_STEPS + 1);
   localparam int ACC_W    = STEP_W + gmr_pkg::DIR_W;
   localparam int PT_W     = (ACC_W + 1 > 21) ? ACC_W + 1 : 21;
   localparam int SPAN     = CELL_SIZE * gmr_pkg::FRAC_SCALE;
   localparam int SPAN_LOG = $clog2(SPAN);
   localparam int LIMIT    = MAP_SIDE * SPAN;
   localparam int DIV_W    = $clog2(LIMIT);
   localparam int PROD_W   = 2 * DIV_W + 1;
   localparam int COORD_W  = $clog2(MAP_SIDE);
   localparam int LIN_W    = 2 * COORD_W + 1;
   localparam int Q_LSB    = DIV_W + SPAN_LOG;

   // round-up reciprocal, exact quotient for every dividend below 2^DIV_W
   localparam longint RECIP_WIDE =
      ((longint'(1) << (DIV_W + SPAN_LOG)) / longint'(SPAN)) + longint'(1);
   localparam logic [DIV_W:0] RECIP = RECIP_WIDE[DIV_W:0];

   logic [gmr_pkg::TYPE_W-1:0]         map_mem [gmr_pkg::MAP_DEPTH];

   logic [1:0]                         state_ff;
   logic [1:0]                         state_in;
   logic [gmr_pkg::POS_W-1:0]          sx_ff;
   logic [gmr_pkg::POS_W-1:0]          sy_ff;
   logic signed [gmr_pkg::DIR_W-1:0]   dx_ff;
   logic signed [gmr_pkg::DIR_W-1:0]   dy_ff;
   logic signed [ACC_W-1:0]            acc_x_ff;
   logic signed [ACC_W-1:0]            acc_y_ff;
   logic [STEP_W-1:0]                  step_ff;

   logic                               s1_valid_ff;
   logic                               s1_last_ff;
   logic signed [PT_W-1:0]             s1_px_ff;
   logic signed [PT_W-1:0]             s1_py_ff;

   logic                               s2_valid_ff;
   logic                               s2_last_ff;
   logic                               s2_wall_ff;
   logic signed [PT_W-1:0]             s2_px_ff;
   logic signed [PT_W-1:0]             s2_py_ff;
   logic [PROD_W-1:0]                  s2_prod_x_ff;
   logic [PROD_W-1:0]                  s2_prod_y_ff;

   logic                               s3_valid_ff;
   logic                               s3_last_ff;
   logic                               s3_wall_ff;
   logic signed [PT_W-1:0]             s3_px_ff;
   logic signed [PT_W-1:0]             s3_py_ff;
   logic [gmr_pkg::TYPE_W-1:0]         cell_rd_ff;

   logic                               rsp_hit_ff;
   logic [gmr_pkg::POS_W-1:0]          rsp_x_ff;
   logic [gmr_pkg::POS_W-1:0]          rsp_y_ff;
   logic [gmr_pkg::TYPE_W-1:0]         rsp_type_ff;

   logic signed [PT_W-1:0]             off_x;
   logic signed [PT_W-1:0]             off_y;
   logic signed [PT_W-1:0]             px_in;
   logic signed [PT_W-1:0]             py_in;
   logic                               wall_in;
   logic [COORD_W-1:0]                 qx;
   logic [COORD_W-1:0]                 qy;
   logic [LIN_W-1:0]                   lin;
   logic [gmr_pkg::INDEX_W-1:0]        rd_idx;
   logic [gmr_pkg::TYPE_W-1:0]         cell_t;
   logic                               s3_hit;
   logic                               finish;
   logic                               issue;
   logic                               pop_write;
   logic                               pop_cast;

   function automatic logic [gmr_pkg::POS_W-1:0] clamp_pos(input logic signed [PT_W-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > $signed(PT_W'({gmr_pkg::POS_W{1'b1}}))) begin
         return '1;
      end
      return v[gmr_pkg::POS_W-1:0];
   endfunction

   assign q_pop     = q_valid && (state_ff == B_IDLE);
   assign pop_write = q_pop && (q_data.command == gmr_pkg::CMD_WRITE);
   assign pop_cast  = q_pop && (q_data.command == gmr_pkg::CMD_CAST);

   assign rsp_if.valid    = (state_ff == B_DONE);
   assign rsp_if.hit      = rsp_hit_ff;
   assign rsp_if.hit_x    = rsp_x_ff;
   assign rsp_if.hit_y    = rsp_y_ff;
   assign rsp_if.hit_type = rsp_type_ff;

   // step point: start plus floor((dir * step + 128) / 256)
   always_comb begin
      off_x = PT_W'(acc_x_ff >>> gmr_pkg::STEP_SHIFT);
      off_y = PT_W'(acc_y_ff >>> gmr_pkg::STEP_SHIFT);
      px_in = $signed(PT_W'({1'b0, sx_ff})) + off_x;
      py_in = $signed(PT_W'({1'b0, sy_ff})) + off_y;
   end

   // negative or past the far edge is a wall
   assign wall_in = s1_px_ff[PT_W-1] || s1_py_ff[PT_W-1] ||
                    (s1_px_ff >= $signed(PT_W'(LIMIT))) ||
                    (s1_py_ff >= $signed(PT_W'(LIMIT)));

   always_comb begin
      qx     = s2_prod_x_ff[Q_LSB +: COORD_W];
      qy     = s2_prod_y_ff[Q_LSB +: COORD_W];
      lin    = LIN_W'(qy) * LIN_W'(MAP_SIDE) + LIN_W'(qx);
      rd_idx = gmr_pkg::INDEX_W'(lin);
   end

   always_comb begin
      cell_t = s3_wall_ff ? gmr_pkg::TYPE_WALL : cell_rd_ff;
      s3_hit = s3_valid_ff && (cell_t != gmr_pkg::TYPE_EMPTY);
      finish = s3_valid_ff && (s3_hit || s3_last_ff);
      issue  = (state_ff == B_RUN) && (step_ff != STEP_W'(MAX_STEPS)) && !finish;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_cast) begin
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (finish) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (rsp_if.ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         step_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop_cast) begin
            step_ff <= '0;
         end else if (issue) begin
            step_ff <= step_ff + STEP_W'(1);
         end
         // steps behind the first hit are dropped
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff && !finish;
         s3_valid_ff <= s2_valid_ff && !finish;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_cast) begin
         sx_ff    <= q_data.start_x;
         sy_ff    <= q_data.start_y;
         dx_ff    <= q_data.dir_x;
         dy_ff    <= q_data.dir_y;
         acc_x_ff <= ACC_W'(gmr_pkg::STEP_ROUND);
         acc_y_ff <= ACC_W'(gmr_pkg::STEP_ROUND);
      end else if (issue) begin
         acc_x_ff <= acc_x_ff + ACC_W'(dx_ff);
         acc_y_ff <= acc_y_ff + ACC_W'(dy_ff);
      end

      s1_px_ff   <= px_in;
      s1_py_ff   <= py_in;
      s1_last_ff <= (step_ff == STEP_W'(MAX_STEPS - 1));

      s2_px_ff     <= s1_px_ff;
      s2_py_ff     <= s1_py_ff;
      s2_last_ff   <= s1_last_ff;
      s2_wall_ff   <= wall_in;
      s2_prod_x_ff <= PROD_W'(s1_px_ff[DIV_W-1:0]) * PROD_W'(RECIP);
      s2_prod_y_ff <= PROD_W'(s1_py_ff[DIV_W-1:0]) * PROD_W'(RECIP);

      s3_px_ff   <= s2_px_ff;
      s3_py_ff   <= s2_py_ff;
      s3_last_ff <= s2_last_ff;
      s3_wall_ff <= s2_wall_ff;

      if (finish) begin
         rsp_hit_ff  <= s3_hit;
         rsp_x_ff    <= s3_hit ? clamp_pos(s3_px_ff) : '0;
         rsp_y_ff    <= s3_hit ? clamp_pos(s3_py_ff) : '0;
         rsp_type_ff <= s3_hit ? cell_t : gmr_pkg::TYPE_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_write) begin
         map_mem[q_data.cell_index] <= q_data.cell_type;
      end
      cell_rd_ff <= map_mem[rd_idx];
   end

endmodule

`default_nettype wire

// File: rtl/grid_ray_march_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  transaction payload
// req_if    in   command, cell_index, cell_type, start_x, start_y, ray_angle
// rsp_if    out  hit, hit_x, hit_y, hit_type (one per cast, none per map write)
//
// a map write is pushed into the queue in the cycle it is taken and gives no result
// a cast reads the sine and then the cosine on the front's table port,
// then runs in the march unit: one map read per step on the single map read port,
// ending early at the first hit
// reset is synchronous and clears control state; the map holds garbage until written
// the two-entry queue keeps the front taking transactions while a cast runs
// or its result waits on rsp_if.ready

module grid_ray_march_core #(
   parameter int MAP_SIDE  = gmr_pkg::MAP_SIDE_DEF,
   parameter int MAX_STEPS = gmr_pkg::MAX_STEPS_DEF,
   parameter int CELL_SIZE = gmr_pkg::CELL_SIZE_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   gmr_req_if.sink   req_if,
   gmr_rsp_if.source rsp_if
);

   gmr_pkg::entry_type push_data;
   gmr_pkg::entry_type pop_data;
   logic               push;
   logic               full;
   logic               pop;
   logic               q_valid;

   gmr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .q_full      (full),
      .q_push      (push),
      .q_push_data (push_data)
   );

   gmr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   gmr_march #(
      .MAP_SIDE  (MAP_SIDE),
      .MAX_STEPS (MAX_STEPS),
      .CELL_SIZE (CELL_SIZE)
   ) u_march (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp_if  (rsp_if)
   );

endmodule

`default_nettype wire

// File: rtl/gmr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gmr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_hit,
   input wire logic [gmr_pkg::POS_W-1:0]  rsp_hit_x,
   input wire logic [gmr_pkg::POS_W-1:0]  rsp_hit_y,
   input wire logic [gmr_pkg::TYPE_W-1:0] rsp_hit_type
);

   // a miss carries no point and no type
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_hit_x == '0) && (rsp_hit_y == '0) && (rsp_hit_type == gmr_pkg::TYPE_EMPTY))
      else $error("miss result with nonzero fields");

   // a hit always names a non-empty block
   a_hit_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_hit_type != gmr_pkg::TYPE_EMPTY))
      else $error("hit result with empty type");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable(rsp_hit) && $stable(rsp_hit_x) &&
         $stable(rsp_hit_y) && $stable(rsp_hit_type))
      else $error("stalled result changed");

   // nothing is left to deliver right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind grid_ray_march_core gmr_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_hit      (rsp_if.hit),
   .rsp_hit_x    (rsp_if.hit_x),
   .rsp_hit_y    (rsp_if.hit_y),
   .rsp_hit_type (rsp_if.hit_type)
);

`default_nettype wire

// File: bench/tb_grid_ray_march_core.sv
`timescale 1ns / 1ps

module tb_grid_ray_march_core;

   localparam int MAP_SIDE  = gmr_pkg::MAP_SIDE_DEF;
   localparam int MAX_STEPS = gmr_pkg::MAX_STEPS_DEF;
   localparam int CELL_SIZE = gmr_pkg::CELL_SIZE_DEF;
   localparam int MAP_CELLS = gmr_pkg::MAP_DEPTH;

   localparam int INDEX_W      = gmr_pkg::INDEX_W;
   localparam int TYPE_W       = gmr_pkg::TYPE_W;
   localparam int POS_W        = gmr_pkg::POS_W;
   localparam int ANGLE_W      = gmr_pkg::ANGLE_W;
   localparam int QUARTER_TURN = gmr_pkg::QUARTER_TURN;
   localparam int HALF_TURN    = gmr_pkg::HALF_TURN;
   localparam int THREE_TURN   = gmr_pkg::THREE_TURN;
   localparam int FULL_TURN    = gmr_pkg::FULL_TURN;

   localparam longint ONE_Q30    = longint'(1) << 30;
   localparam longint PI_FIXED   = 64'sd3373259426;
   localparam longint CELL_SPAN  = longint'(CELL_SIZE) * gmr_pkg::FRAC_SCALE;
   localparam longint POS_MAX    = (longint'(1) << POS_W) - 1;
   localparam int     ROUND_HALF = 128;
   localparam int     OFF_SHIFT  = 8;

   localparam int HOLD_CYCLES = 3000;
   localparam int QUIET_LIMIT = 20000;
   localparam int MAX_PRINTED = 40;

   typedef enum logic {PACE_FULL, PACE_RANDOM} pace_type;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] cell_index;
      logic [TYPE_W-1:0]  cell_type;
      logic [POS_W-1:0]   start_x;
      logic [POS_W-1:0]   start_y;
      logic [ANGLE_W-1:0] ray_angle;
   } map_op_type;

   typedef struct packed {
      logic              hit;
      logic [POS_W-1:0]  hit_x;
      logic [POS_W-1:0]  hit_y;
      logic [TYPE_W-1:0] hit_type;
   } ray_result_type;

   logic clock;
   logic reset;

   gmr_req_if req_if ();
   gmr_rsp_if rsp_if ();

   grid_ray_march_core #(
      .MAP_SIDE  (MAP_SIDE),
      .MAX_STEPS (MAX_STEPS),
      .CELL_SIZE (CELL_SIZE)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [TYPE_W-1:0] tile_map [MAP_CELLS];
   ray_result_type    pending_hits [$];

   pace_type pace;
   int       hold_requests;
   int       error_count;
   int       write_count;
   int       cast_count;
   int       hit_count;
   int       miss_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   // angle k * pi / 2048 in q2.30
   function automatic longint turn_angle_q30(input longint k);
      return (k * PI_FIXED + 64'sd1024) / 64'sd2048;
   endfunction

   // taylor series in q2.30, products truncated toward zero
   function automatic longint sine_series(input longint x, input bit odd);
      longint x2;
      longint term;
      longint acc;
      longint div;
      x2   = (x * x) / ONE_Q30;
      term = odd ? x : ONE_Q30;
      acc  = term;
      for (int n = 1; n <= 8; n++) begin
         div  = odd ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
         term = -((term * x2) / ONE_Q30) / div;
         acc  = acc + term;
      end
      return acc;
   endfunction

   function automatic longint quadrant_sine(input int k);
      longint v;
      if (k <= QUARTER_TURN / 2) begin
         v = sine_series(turn_angle_q30(longint'(k)), 1'b1);
      end else begin
         v = sine_series(turn_angle_q30(longint'(QUARTER_TURN - k)), 1'b0);
      end
      if (v < 0) begin
         v = 0;
      end
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic longint sine_at(input int a);
      int w;
      w = a & (FULL_TURN - 1);
      if (w <= QUARTER_TURN) begin
         return quadrant_sine(w);
      end else if (w <= HALF_TURN) begin
         return quadrant_sine(HALF_TURN - w);
      end else if (w <= THREE_TURN) begin
         return -quadrant_sine(w - HALF_TURN);
      end
      return -quadrant_sine(FULL_TURN - w);
   endfunction

   function automatic logic [POS_W-1:0] pos_clamp(input longint v);
      if (v < 0) begin
         return '0;
      end else if (v > POS_MAX) begin
         return {POS_W{1'b1}};
      end
      return POS_W'(v);
   endfunction

   function automatic ray_result_type march_ray(input map_op_type op);
      longint            dx;
      longint            dy;
      longint            px;
      longint            py;
      longint            cx;
      longint            cy;
      logic [TYPE_W-1:0] t;
      ray_result_type    r;
      dx = sine_at(int'(op.ray_angle) + QUARTER_TURN);
      dy = sine_at(int'(op.ray_angle));
      r  = '0;
      for (int i = 0; i < MAX_STEPS; i++) begin
         px = longint'(op.start_x) + ((dx * i + ROUND_HALF) >>> OFF_SHIFT);
         py = longint'(op.start_y) + ((dy * i + ROUND_HALF) >>> OFF_SHIFT);
         if (px < 0 || py < 0) begin
            t = gmr_pkg::TYPE_WALL;
         end else begin
            cx = px / CELL_SPAN;
            cy = py / CELL_SPAN;
            if (cx >= MAP_SIDE || cy >= MAP_SIDE) begin
               t = gmr_pkg::TYPE_WALL;
            end else begin
               t = tile_map[(cx + cy * MAP_SIDE) % MAP_CELLS];
            end
         end
         if (t != gmr_pkg::TYPE_EMPTY) begin
            r.hit      = 1'b1;
            r.hit_x    = pos_clamp(px);
            r.hit_y    = pos_clamp(py);
            r.hit_type = t;
            return r;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- item builders

   function automatic map_op_type write_op(input logic [INDEX_W-1:0] idx,
                                           input logic [TYPE_W-1:0] kind);
      map_op_type op;
      op.command    = gmr_pkg::CMD_WRITE;
      op.cell_index = idx;
      op.cell_type  = kind;
      op.start_x    = POS_W'($urandom());
      op.start_y    = POS_W'($urandom());
      op.ray_angle  = ANGLE_W'($urandom());
      return op;
   endfunction

   function automatic map_op_type cast_op(input logic [POS_W-1:0] x,
                                          input logic [POS_W-1:0] y,
                                          input logic [ANGLE_W-1:0] ang);
      map_op_type op;
      op.command    = gmr_pkg::CMD_CAST;
      op.cell_index = INDEX_W'($urandom());
      op.cell_type  = TYPE_W'($urandom());
      op.start_x    = x;
      op.start_y    = y;
      op.ray_angle  = ang;
      return op;
   endfunction

   function automatic map_op_type random_cast();
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [ANGLE_W-1:0] ang;
      x   = POS_W'($urandom_range(0, 65535));
      y   = POS_W'($urandom_range(0, 65535));
      ang = ANGLE_W'($urandom_range(0, FULL_TURN - 1));
      if ($urandom_range(0, 9) == 0) begin
         x = ($urandom_range(0, 1) != 0) ? {POS_W{1'b1}} : '0;
      end
      if ($urandom_range(0, 9) == 0) begin
         y = ($urandom_range(0, 1) != 0) ? {POS_W{1'b1}} : '0;
      end
      // axis directions and their neighbors
      if ($urandom_range(0, 6) == 0) begin
         ang = ANGLE_W'($urandom_range(0, 3) * QUARTER_TURN + $urandom_range(0, 2)
                        + FULL_TURN - 1);
      end
      return cast_op(x, y, ang);
   endfunction

   function automatic map_op_type random_op();
      logic [TYPE_W-1:0] kind;
      if ($urandom_range(0, 99) < 30) begin
         kind = ($urandom_range(0, 99) < 75) ? gmr_pkg::TYPE_EMPTY
                                              : TYPE_W'($urandom_range(1, 3));
         return write_op(INDEX_W'($urandom_range(0, MAP_CELLS - 1)), kind);
      end
      return random_cast();
   endfunction

   // mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_op(input map_op_type op);
      int gap;
      req_if.valid      <= 1'b1;
      req_if.command    <= op.command;
      req_if.cell_index <= op.cell_index;
      req_if.cell_type  <= op.cell_type;
      req_if.start_x    <= op.start_x;
      req_if.start_y    <= op.start_y;
      req_if.ray_angle  <= op.ray_angle;
      do @(posedge clock); while (!req_if.ready);
      if (op.command == gmr_pkg::CMD_WRITE) begin
         tile_map[op.cell_index] = op.cell_type;
         write_count++;
      end else begin
         pending_hits.push_back(march_ray(op));
         cast_count++;
      end
      gap = (pace == PACE_RANDOM) ? pick_gap() : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_hits.size() != 0);
   endtask

   // ---------------------------------------------------------------- result side

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   task automatic check_result();
      ray_result_type want;
      if (pending_hits.size() == 0) begin
         flag_error($sformatf("result with no cast waiting: hit=%0b x=%0d y=%0d type=%0d",
                              rsp_if.hit, rsp_if.hit_x, rsp_if.hit_y, rsp_if.hit_type));
         return;
      end
      want = pending_hits.pop_front();
      if (want.hit) begin
         hit_count++;
      end else begin
         miss_count++;
      end
      if (rsp_if.hit !== want.hit) begin
         flag_error($sformatf("hit %0b, expected %0b", rsp_if.hit, want.hit));
      end
      if (rsp_if.hit_x !== want.hit_x) begin
         flag_error($sformatf("hit_x %0d, expected %0d", rsp_if.hit_x, want.hit_x));
      end
      if (rsp_if.hit_y !== want.hit_y) begin
         flag_error($sformatf("hit_y %0d, expected %0d", rsp_if.hit_y, want.hit_y));
      end
      if (rsp_if.hit_type !== want.hit_type) begin
         flag_error($sformatf("hit_type %0d, expected %0d", rsp_if.hit_type, want.hit_type));
      end
   endtask

   initial begin : result_side
      int stall_left;
      int hold_left;
      int holds_seen;
      stall_left   = 0;
      hold_left    = 0;
      holds_seen   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            check_result();
         end
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (pace == PACE_RANDOM && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no transaction for %0d cycles, %0d casts outstanding",
               QUIET_LIMIT, pending_hits.size());
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // every cell written once so that no lookup reads an unwritten cell
   task automatic load_empty_map();
      for (int k = 0; k < MAP_CELLS; k++) begin
         send_op(write_op(INDEX_W'(k), gmr_pkg::TYPE_EMPTY));
      end
   endtask

   task automatic test_open_map_misses();
      send_op(cast_op(16'd0, 16'd0, 12'd0));
      send_op(cast_op(16'd20000, 16'd20000, 12'd512));
   endtask

   // negative coordinates, far edges and saturation of the hit point
   task automatic test_leaving_map();
      send_op(cast_op(16'd0, 16'd0, ANGLE_W'(HALF_TURN)));
      send_op(cast_op(16'd0, 16'd0, ANGLE_W'(THREE_TURN)));
      send_op(cast_op(16'hFFFF, 16'hFFFF, 12'd0));
      send_op(cast_op(16'hFFFF, 16'hFFFF, ANGLE_W'(QUARTER_TURN)));
      send_op(cast_op(16'hFFFF, 16'd100, 12'd4095));
      send_op(cast_op(16'd100, 16'd0, 12'd4095));
   endtask

   task automatic test_cell_hits();
      send_op(write_op(8'd136, 2'd2));
      send_op(write_op(8'd195, 2'd3));
      send_op(write_op(8'd15, gmr_pkg::TYPE_WALL));
      // starting inside a filled cell hits at the start point
      send_op(cast_op(16'd32868, 16'd32868, 12'd1536));
      send_op(cast_op(16'd24576, 16'd34816, 12'd0));
      send_op(cast_op(16'd14336, 16'd40960, ANGLE_W'(QUARTER_TURN)));
      send_op(cast_op(16'd53248, 16'd2048, 12'd0));
      // cleared cell lets the same ray pass
      send_op(write_op(8'd136, gmr_pkg::TYPE_EMPTY));
      send_op(cast_op(16'd24576, 16'd34816, 12'd0));
   endtask

   // start near the edge the ray points at so each direction ends in a hit, at the map exit or at the wall in cell 15
   task automatic test_direction_landmarks();
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      for (int k = 0; k < 8; k++) begin
         x = (sine_at(k * 512 + QUARTER_TURN) >= 0) ? 16'd62000 : 16'd3000;
         y = (sine_at(k * 512) >= 0) ? 16'd62000 : 16'd3000;
         send_op(cast_op(x, y, ANGLE_W'(k * 512)));
      end
   endtask

   task automatic test_random_traffic(input int count, input pace_type mode);
      pace <= mode;
      for (int k = 0; k < count; k++) begin
         send_op(random_op());
      end
   endtask

   // output held off while casts keep coming, so the queue fills and stalls
   task automatic test_output_backpressure();
      pace          <= PACE_FULL;
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 8; k++) begin
         send_op(random_cast());
      end
      wait_results_drained();
   endtask

   task automatic test_drain_pause();
      pace <= PACE_RANDOM;
      for (int k = 0; k < 12; k++) begin
         send_op(random_op());
      end
      wait_results_drained();
      for (int k = 0; k < 12; k++) begin
         send_op(random_op());
      end
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      pace              = PACE_RANDOM;
      hold_requests     = 0;
      error_count       = 0;
      write_count       = 0;
      cast_count        = 0;
      hit_count         = 0;
      miss_count        = 0;
      req_if.valid      = 1'b0;
      req_if.command    = gmr_pkg::CMD_WRITE;
      req_if.cell_index = '0;
      req_if.cell_type  = '0;
      req_if.start_x    = '0;
      req_if.start_y    = '0;
      req_if.ray_angle  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      load_empty_map();
      test_open_map_misses();
      test_leaving_map();
      test_cell_hits();
      test_direction_landmarks();
      test_random_traffic(40, PACE_RANDOM);
      test_output_backpressure();
      test_random_traffic(25, PACE_FULL);
      test_drain_pause();
      test_random_traffic(25, PACE_RANDOM);

      wait_results_drained();
      repeat (MAX_STEPS + 32) @(posedge clock);
      if (pending_hits.size() != 0) begin
         flag_error($sformatf("%0d casts never answered", pending_hits.size()));
      end
      $display("covered %0d map writes and %0d ray casts: %0d hits, %0d misses",
               write_count, cast_count, hit_count, miss_count);
      $display("map edges, saturated hit points, axis angles, output hold-off and drain");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
